// ===== hw/rtl/gcra_pkg.sv =====
// Shared types and constants for the glyph cursor row address generator.
// Depends on nothing; every other file of the block imports it.
package gcra_pkg;

    localparam int MAX_CELL_HEIGHT = 64;

    localparam logic [12:0] WINDOW_WIDTH_RST  = 13'd800;
    localparam logic [12:0] WINDOW_HEIGHT_RST = 13'd480;
    localparam logic [6:0]  CELL_HEIGHT_RST   = 7'd16;
    localparam logic [13:0] LINE_STRIDE_RST   = 14'd800;

    localparam logic [1:0] REG_WINDOW_WIDTH  = 2'd0;
    localparam logic [1:0] REG_WINDOW_HEIGHT = 2'd1;
    localparam logic [1:0] REG_CELL_HEIGHT   = 2'd2;
    localparam logic [1:0] REG_LINE_STRIDE   = 2'd3;

    localparam logic KIND_GLYPH     = 1'b0;
    localparam logic KIND_NEW_FRAME = 1'b1;

    localparam logic STATUS_ROW  = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [9:0]  glyph_width;
        logic [23:0] glyph_base;
    } gcra_in_t;

    typedef struct packed {
        logic [24:0] dest_offset;
        logic [23:0] source_offset;
        logic [9:0]  row_length;
        logic        status;
        logic        last;
    } gcra_out_t;

    // cell_height here is the clamped value, 1..MAX_CELL_HEIGHT
    typedef struct packed {
        logic [12:0] window_width;
        logic [12:0] window_height;
        logic [6:0]  cell_height;
        logic [13:0] line_stride;
    } gcra_cfg_t;

    typedef struct packed {
        logic load;
        logic new_frame;
        logic wrap;
        logic start_rows;
        logic next_row;
        logic advance;
        logic refuse;
    } gcra_cmd_t;

    typedef struct packed {
        logic kind;
        logic zero_width;
        logic full;
        logic wrap;
        logic last_row;
    } gcra_stat_t;

endpackage

// ===== hw/rtl/gcra_cfg.sv =====
// APB-style register file for the glyph cursor row address generator.
// Depends on gcra_pkg.
module gcra_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output gcra_pkg::gcra_cfg_t cfg
);
    import gcra_pkg::*;

    logic [12:0] window_width_reg;
    logic [12:0] window_height_reg;
    logic [6:0]  cell_height_reg;
    logic [13:0] line_stride_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_width_reg  <= WINDOW_WIDTH_RST;
            window_height_reg <= WINDOW_HEIGHT_RST;
            cell_height_reg   <= CELL_HEIGHT_RST;
            line_stride_reg   <= LINE_STRIDE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_WINDOW_WIDTH:  window_width_reg  <= pwdata[12:0];
                REG_WINDOW_HEIGHT: window_height_reg <= pwdata[12:0];
                REG_CELL_HEIGHT:   cell_height_reg   <= pwdata[6:0];
                REG_LINE_STRIDE:   line_stride_reg   <= pwdata[13:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_WINDOW_WIDTH:  prdata = {19'd0, window_width_reg};
            REG_WINDOW_HEIGHT: prdata = {19'd0, window_height_reg};
            REG_CELL_HEIGHT:   prdata = {25'd0, cell_height_reg};
            REG_LINE_STRIDE:   prdata = {18'd0, line_stride_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // zero acts as one row, anything above the maximum as the maximum
    always_comb
    begin
        cfg.window_width  = window_width_reg;
        cfg.window_height = window_height_reg;
        cfg.line_stride   = line_stride_reg;
        priority if (cell_height_reg == 7'd0)
            cfg.cell_height = 7'd1;
        else if (cell_height_reg > 7'(MAX_CELL_HEIGHT))
            cfg.cell_height = 7'(MAX_CELL_HEIGHT);
        else
            cfg.cell_height = cell_height_reg;
    end

endmodule

// ===== hw/rtl/gcra_ctrl.sv =====
// Sequencer for the glyph cursor row address generator.
// Depends on gcra_pkg; drives gcra_dp through command and status structs.
module gcra_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  gcra_pkg::gcra_stat_t stat,
    output gcra_pkg::gcra_cmd_t  cmd
);
    import gcra_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_WRAP  = 6'b000100,
        ST_SETUP = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_FULL  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT) || (state_reg == ST_FULL);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.refuse = (state_reg == ST_FULL);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (stat.kind == KIND_NEW_FRAME)
                        cmd.new_frame = 1'b1;
                    else if (!stat.zero_width)
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                priority if (stat.full)
                    state_next = ST_FULL;
                else if (stat.wrap)
                begin
                    cmd.wrap   = 1'b1;
                    state_next = ST_WRAP;
                end
                else
                    state_next = ST_SETUP;
            end
            ST_WRAP:
                state_next = stat.full ? ST_FULL : ST_SETUP;
            ST_SETUP:
            begin
                cmd.start_rows = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    cmd.next_row = 1'b1;
                    if (stat.last_row)
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_FULL:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/gcra_dp.sv =====
// Datapath of the glyph cursor row address generator: cursor, item latch,
// row address counters. Depends on gcra_pkg.
module gcra_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gcra_pkg::gcra_cfg_t  cfg,
    input  gcra_pkg::gcra_in_t   in_data,
    input  gcra_pkg::gcra_cmd_t  cmd,
    output gcra_pkg::gcra_stat_t stat,
    output gcra_pkg::gcra_out_t  out_data
);
    import gcra_pkg::*;

    logic [12:0] cur_x_reg;
    logic [12:0] cur_y_reg;
    logic [9:0]  gw_reg;
    logic [23:0] base_reg;
    logic [24:0] dst_reg;
    logic [23:0] src_reg;
    logic [6:0]  row_reg;

    logic [13:0] y_plus_ch;
    logic [13:0] x_plus_gw;
    logic [12:0] wrap_y;
    logic [26:0] row_prod;
    logic [24:0] dst_start;

    assign y_plus_ch = {1'b0, cur_y_reg} + {7'd0, cfg.cell_height};
    assign x_plus_gw = {1'b0, cur_x_reg} + {4'd0, gw_reg};
    // next text row, pinned at the top of the cursor range
    assign wrap_y    = y_plus_ch[13] ? 13'h1FFF : y_plus_ch[12:0];
    assign row_prod  = 27'(cur_y_reg) * 27'(cfg.line_stride);
    assign dst_start = row_prod[24:0] + {12'd0, cur_x_reg};

    assign stat.kind       = in_data.kind;
    assign stat.zero_width = (in_data.glyph_width == 10'd0);
    assign stat.full       = y_plus_ch > {1'b0, cfg.window_height};
    assign stat.wrap       = x_plus_gw > {1'b0, cfg.window_width};
    assign stat.last_row   = (row_reg == cfg.cell_height - 7'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg <= 13'd0;
            cur_y_reg <= 13'd0;
        end
        else
        begin
            if (cmd.new_frame)
            begin
                cur_x_reg <= 13'd0;
                cur_y_reg <= 13'd0;
            end
            else if (cmd.wrap)
            begin
                cur_x_reg <= 13'd0;
                cur_y_reg <= wrap_y;
            end
            else if (cmd.advance)
                cur_x_reg <= x_plus_gw[12:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            gw_reg   <= in_data.glyph_width;
            base_reg <= in_data.glyph_base;
        end
        if (cmd.start_rows)
        begin
            dst_reg <= dst_start;
            src_reg <= base_reg;
            row_reg <= 7'd0;
        end
        else if (cmd.next_row)
        begin
            dst_reg <= dst_reg + {11'd0, cfg.line_stride};
            src_reg <= src_reg + {14'd0, gw_reg};
            row_reg <= row_reg + 7'd1;
        end
    end

    always_comb
    begin
        if (cmd.refuse)
        begin
            out_data.dest_offset   = 25'd0;
            out_data.source_offset = 24'd0;
            out_data.row_length    = 10'd0;
            out_data.status        = STATUS_FULL;
            out_data.last          = 1'b1;
        end
        else
        begin
            out_data.dest_offset   = dst_reg;
            out_data.source_offset = src_reg;
            out_data.row_length    = gw_reg;
            out_data.status        = STATUS_ROW;
            out_data.last          = stat.last_row;
        end
    end

endmodule

// ===== hw/rtl/glyph_cursor_row_address_gen.sv =====
// Top level of the glyph cursor row address generator.
// Depends on gcra_pkg, gcra_cfg, gcra_ctrl and gcra_dp.
//
// Usage:
//   in_*   : one word per glyph or new-frame command (gcra_in_t), valid/ready.
//   out_*  : row copy commands and frame-full refusals (gcra_out_t),
//            valid/ready; the final word of each glyph carries last = 1.
//   APB    : window_width 0x0, window_height 0x4, cell_height 0x8,
//            line_stride 0xC; write only while the block is idle.
// Timing:
//   Words are handled one at a time; in_ready is high only while idle.
//   A new-frame or zero-width word yields nothing and leaves the block idle.
//   A placed glyph goes through check, wrap (only when it wraps) and setup,
//   then yields one row per cycle while out_ready is high.
//   The row sequencer, one row address add per cycle, sets this rate.
//   A refused glyph yields its status word after check (and wrap, if it wraps).
// Stall: the output word is held in registers; the sequencer stops while
//   out_ready is low and resumes without loss.
// Reset: cursor at (0,0), registers at 800 / 480 / 16 / 800, idle.
module glyph_cursor_row_address_gen (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gcra_pkg::gcra_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output gcra_pkg::gcra_out_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import gcra_pkg::*;

    gcra_cfg_t  cfg;
    gcra_cmd_t  cmd;
    gcra_stat_t stat;

    gcra_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: glyph decision, wrap, row emission
    gcra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // cursor and address counters
    gcra_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

    // one word in flight: never taking input while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while output pending");

    a_full_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == STATUS_FULL)
            |-> (out_data.last && out_data.row_length == 10'd0))
        else $error("refusal word malformed");

    a_row_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == STATUS_ROW) |-> (out_data.row_length != 10'd0))
        else $error("row command with zero length");

    // rows of one glyph come back to back
    a_rows_contig: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_data.last) |=> out_valid)
        else $error("gap inside a glyph's rows");

endmodule
